// ===== hdl/gbn_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the
// go-back-n window sender; no dependencies
package gbn_pkg;

  localparam int unsigned WIN_MAX = 64;   // window limit, also the number of timer slots
  localparam int unsigned NSLOT   = 64;
  localparam int unsigned SLOT_W  = 6;    // slot = seq mod 64
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned THR_W   = 7;
  localparam int unsigned TMR_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W   = 16;

  localparam logic [SEQ_W-1:0] SEQ_TOP   = 32'hFFFF_FFFF;
  localparam logic [SEQ_W-1:0] SEG_MAX   = 32'hFFFF_FFFE;
  localparam logic [THR_W-1:0] THR_RESET = 7'd32;
  localparam logic [TMR_W-1:0] TMO_RESET = 16'd1;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WIN_MAX);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;

  typedef struct packed {
    logic load_in;
    logic start;
    logic zero_ack;
    logic ack;
    logic grow;
    logic shrink;
    logic loop_init;
    logic loop_step;
    logic resend;
    logic sweep_start;
    logic sweep_run;
  } gbn_cmd_t;

  typedef struct packed {
    logic [1:0] cmd_code;
    logic       busy;
    logic       ack_zero;
    logic       ack_in_order;
    logic       ack_hits_end;
    logic       loop_done;
    logic       out_free;
    logic       sweep_done;
    logic       fired;
  } gbn_sts_t;

endpackage

// ===== hdl/gbn_ctrl.sv =====
// sequencing state machine of the window sender: decodes a command and
// steps the datapath through send, sweep and resend; uses gbn_pkg
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  gbn_sts_t sts,
  output gbn_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_SHRINK = 3'd3;
  localparam logic [2:0] ST_LINIT  = 3'd4;
  localparam logic [2:0] ST_LOOP   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       resend_r, resend_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    resend_nxt = resend_r;
    cmd        = '0;
    cmd.resend = resend_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (sts.cmd_code)
          CMD_START: begin
            cmd.start  = 1'b1;
            resend_nxt = 1'b0;
            state_nxt  = ST_LINIT;
          end
          CMD_ACK: begin
            if (sts.busy) begin
              if (sts.ack_zero) begin
                // the completion result needs the output register
                if (sts.out_free) begin
                  cmd.zero_ack = 1'b1;
                end else begin
                  state_nxt = ST_DECODE;
                end
              end else if (sts.ack_in_order) begin
                cmd.ack = 1'b1;
                if (sts.ack_hits_end) begin
                  cmd.grow   = 1'b1;
                  resend_nxt = 1'b0;
                  state_nxt  = ST_LINIT;
                end
              end
            end
          end
          CMD_TICK: begin
            if (sts.busy) begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_SWEEP;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = sts.fired ? ST_SHRINK : ST_IDLE;
        end
      end
      ST_SHRINK: begin
        cmd.shrink = 1'b1;
        resend_nxt = 1'b1;
        state_nxt  = ST_LINIT;
      end
      ST_LINIT: begin
        cmd.loop_init = 1'b1;
        state_nxt     = ST_LOOP;
      end
      ST_LOOP: begin
        if (sts.loop_done) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.loop_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      resend_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      resend_r <= resend_nxt;
    end
  end

endmodule

// ===== hdl/gbn_dp.sv =====
// datapath of the window sender: window registers, slot timer memory with
// active bits, send loop counters and the output register; uses gbn_pkg
module gbn_dp
  import gbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [63:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast,
  input  gbn_cmd_t             cmd,
  output gbn_sts_t             sts
);

  // configuration
  logic [THR_W-1:0] thr_cfg_r;
  logic [TMR_W-1:0] tmo_cfg_r;
  logic [TMR_W-1:0] tmo_eff;

  // latched input item
  logic [1:0]       in_cmd_r;
  logic [SEQ_W-1:0] in_ack_r;
  logic [SEQ_W-1:0] in_cnt_r;

  // window state
  logic [SEQ_W-1:0] acked_r, wend_r, marker_r, total_r;
  logic [LEN_W-1:0] wlen_r;
  logic [THR_W-1:0] thr_r;
  logic             busy_r;

  // send loop
  logic [SEQ_W:0]   s_r;
  logic [LEN_W-1:0] k_r, c_r;
  logic             stop_r;

  // timer sweep
  logic [SLOT_W:0]   idx_r;
  logic              sv_r;
  logic [SLOT_W-1:0] saddr_r;
  logic              fired_r;
  logic [TMR_W-1:0]  timer_mem [NSLOT];
  logic [TMR_W-1:0]  rd_data_r;
  logic [NSLOT-1:0]  active_r, active_nxt;

  // output register
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic              out_rt_r, out_last_r;

  // combinational helpers
  logic [LEN_W:0]    len_dbl, len_inc, len_grow8, shr_sum;
  logic [LEN_W-1:0]  len_grow, len_shr;
  logic [THR_W-1:0]  thr_half;
  logic [SEQ_W-1:0]  room, span_raw;
  logic [LEN_W-1:0]  span_cap;
  logic              s_le_total, s_le_marker, s_eq_marker, marker_set;
  logic              step_emit, step_end, step_last, step_arm;
  logic [SLOT_W-1:0] s_slot;
  logic              sw_act, sw_fire;
  logic [TMR_W-1:0]  sw_dec;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [TMR_W-1:0]  mem_wdata;
  logic              emit_load;

  assign tmo_eff = (tmo_cfg_r == '0) ? TMO_RESET : tmo_cfg_r;

  // window growth on a fully acked window
  assign len_dbl   = {wlen_r, 1'b0};
  assign len_inc   = {1'b0, wlen_r} + (LEN_W+1)'(1);
  assign len_grow8 = (wlen_r < thr_r) ? len_dbl : len_inc;
  assign len_grow  = (len_grow8 > {1'b0, LEN_MAX}) ? LEN_MAX : len_grow8[LEN_W-1:0];
  assign room      = SEQ_TOP - wend_r;

  // timeout shrink
  assign thr_half = thr_r >> 1;
  assign shr_sum  = {1'b0, thr_half} + (LEN_W+1)'(3);
  assign len_shr  = (shr_sum > {1'b0, LEN_MAX}) ? LEN_MAX : shr_sum[LEN_W-1:0];

  // outstanding span, capped at the window limit
  assign span_raw = wend_r - acked_r;
  assign span_cap = (span_raw > SEQ_W'(WIN_MAX)) ? LEN_MAX : span_raw[LEN_W-1:0];

  // one loop step
  assign s_slot      = s_r[SLOT_W-1:0];
  assign s_le_total  = (s_r[SEQ_W-1:0] <= total_r);
  assign s_le_marker = (s_r[SEQ_W-1:0] <= marker_r);
  assign s_eq_marker = (s_r[SEQ_W-1:0] == marker_r);
  assign marker_set  = (marker_r != '0);
  assign step_emit   = !cmd.resend || !marker_set || s_le_marker;
  assign step_end    = cmd.resend ? (marker_set && s_eq_marker) : !s_le_total;
  assign step_last   = (k_r == c_r) || (&s_r[SEQ_W-1:0]) || step_end;
  // a freshly sent end marker runs no timer, a resent one does
  assign step_arm    = step_emit && (cmd.resend || s_le_total);
  assign emit_load   = (cmd.loop_step && step_emit) || cmd.zero_ack;

  // sweep stage on the registered read data
  assign sw_act  = sv_r && active_r[saddr_r];
  assign sw_dec  = (rd_data_r == '0) ? '0 : rd_data_r - TMR_W'(1);
  assign sw_fire = sw_act && (sw_dec == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s_slot;
    mem_wdata = tmo_eff;
    if (cmd.loop_step && step_arm) begin
      mem_we = 1'b1;
    end else if (sw_act) begin
      mem_we    = 1'b1;
      mem_waddr = saddr_r;
      mem_wdata = sw_dec;
    end
  end

  always_comb begin
    active_nxt = active_r;
    if (cmd.start || cmd.zero_ack) begin
      active_nxt = '0;
    end else if (cmd.ack) begin
      active_nxt[in_ack_r[SLOT_W-1:0]] = 1'b0;
    end else if (cmd.loop_step && (cmd.resend || s_le_total)) begin
      active_nxt[s_slot] = step_emit;
    end else if (sw_fire) begin
      active_nxt[saddr_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      timer_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= timer_mem[idx_r[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd_r <= in_tuser;
      in_ack_r <= in_tdata[31:0];
      in_cnt_r <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cfg_r <= THR_RESET;
      tmo_cfg_r <= TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_THR: thr_cfg_r <= cfg_data[THR_W-1:0];
        REG_TIMEOUT:  tmo_cfg_r <= cfg_data[TMR_W-1:0];
        default:      thr_cfg_r <= thr_cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_r  <= '0;
      wend_r   <= SEQ_W'(1);
      wlen_r   <= LEN_W'(1);
      thr_r    <= THR_RESET;
      marker_r <= '0;
      total_r  <= '0;
      busy_r   <= 1'b0;
      active_r <= '0;
      stop_r   <= 1'b0;
      idx_r    <= '0;
      sv_r     <= 1'b0;
      fired_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (cmd.start) begin
        total_r  <= (in_cnt_r > SEG_MAX) ? SEG_MAX : in_cnt_r;
        acked_r  <= '0;
        thr_r    <= thr_cfg_r;
        wlen_r   <= LEN_W'(1);
        wend_r   <= SEQ_W'(1);
        marker_r <= '0;
        busy_r   <= 1'b1;
      end
      if (cmd.zero_ack) begin
        acked_r  <= '0;
        marker_r <= '0;
        busy_r   <= 1'b0;
      end
      if (cmd.ack) begin
        acked_r <= in_ack_r;
      end
      if (cmd.grow) begin
        wlen_r <= len_grow;
        wend_r <= (room < SEQ_W'(len_grow)) ? SEQ_TOP : wend_r + SEQ_W'(len_grow);
      end
      if (cmd.shrink) begin
        thr_r  <= thr_half;
        wlen_r <= len_shr;
      end
      if (cmd.loop_init) begin
        s_r    <= {1'b0, acked_r} + (SEQ_W+1)'(1);
        k_r    <= LEN_W'(1);
        c_r    <= span_cap;
        stop_r <= 1'b0;
      end
      if (cmd.loop_step) begin
        s_r <= s_r + (SEQ_W+1)'(1);
        k_r <= k_r + LEN_W'(1);
        if (!cmd.resend && step_end) begin
          marker_r <= s_r[SEQ_W-1:0];
          stop_r   <= 1'b1;
        end
      end
      // timer sweep: read slot idx, decrement it in the next cycle
      if (cmd.sweep_start) begin
        idx_r   <= '0;
        sv_r    <= 1'b0;
        fired_r <= 1'b0;
      end else if (cmd.sweep_run) begin
        sv_r    <= !idx_r[SLOT_W];
        saddr_r <= idx_r[SLOT_W-1:0];
        if (!idx_r[SLOT_W]) begin
          idx_r <= idx_r + (SLOT_W+1)'(1);
        end
        if (sw_fire) begin
          fired_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_ack) begin
      out_kind_r <= KIND_COMPLETE;
      out_seq_r  <= '0;
      out_rt_r   <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.loop_step && step_emit) begin
      out_kind_r <= step_end ? KIND_END : KIND_DATA;
      out_seq_r  <= s_r[SEQ_W-1:0];
      out_rt_r   <= cmd.resend;
      out_last_r <= step_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_seq_r;
  assign out_tuser  = {out_rt_r, out_kind_r};
  assign out_tlast  = out_last_r;

  assign sts.cmd_code     = in_cmd_r;
  assign sts.busy         = busy_r;
  assign sts.ack_zero     = (in_ack_r == '0);
  assign sts.ack_in_order = (in_ack_r == acked_r + SEQ_W'(1));
  assign sts.ack_hits_end = (in_ack_r == wend_r);
  assign sts.loop_done    = (k_r > c_r) || s_r[SEQ_W] || stop_r;
  assign sts.out_free     = !out_valid_r || out_tready;
  assign sts.sweep_done   = idx_r[SLOT_W] && !sv_r;
  assign sts.fired        = fired_r;

endmodule

// ===== hdl/go_back_n_window_sender.sv =====
// top level of the go-back-n window sender: state machine plus datapath
// depends on gbn_pkg, gbn_ctrl and gbn_dp
//
// usage:
//   in_*  : one command per transfer; tuser = cmd (start, ack, tick),
//           tdata = ack_seq (bits 31:0), segment_count (bits 63:32)
//   out_* : segments to transmit; tdata = seq, tuser = kind (1:0) and
//           retransmit flag (2), tlast on the final result of a command
//   cfg_* : write enable, index 0 initial threshold, index 1 timeout ticks;
//           write only while the block is idle
// timing: one command at a time; in_tready is high only between commands.
//   start and a window-completing ack then run the send loop over the sent
//   segments (up to 64 of them).
//   a tick sweeps the 64 slot timers through the timer memory, one slot a
//   cycle, and on expiry walks the outstanding span (up to 64 sequences)
//   to resend it.
// reset clears the window state, the active bits of all timer slots and the
// output valid flag; no clearing pass. a stalled receiver holds the send loop
// on the output register; nothing is dropped.
module go_back_n_window_sender
  import gbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // ack_seq, segment_count
  input  logic [1:0]           in_tuser,   // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // seq
  output logic [2:0]           out_tuser,  // kind, is_retransmit
  output logic                 out_tlast
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== tb/go_back_n_window_sender_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for go_back_n_window_sender: a scoreboard class predicts the
// segment stream from each accepted command, plain tasks drive commands and config writes
// depends on gbn_pkg and the go_back_n_window_sender rtl
import gbn_pkg::*;

typedef struct {
  logic [1:0]       kind;
  logic [SEQ_W-1:0] seq;
  logic             rtx;
  logic             last;
} seg_item_t;

class segment_scoreboard;
  logic [THR_W-1:0] init_thr;
  logic [TMR_W-1:0] tmo_ticks;
  logic [SEQ_W-1:0] acked;
  logic [SEQ_W-1:0] win_end;
  logic [SEQ_W-1:0] marker;
  logic [SEQ_W-1:0] total;
  int unsigned      win_len;
  int unsigned      thr;
  logic [TMR_W-1:0] timer [NSLOT];
  bit               armed [NSLOT];
  bit               busy;
  seg_item_t        segs_due[$];
  seg_item_t        step_segs[$];
  int unsigned      errors;
  int unsigned      checked;
  int unsigned      resent;
  int unsigned      timeouts;
  int unsigned      commands;

  function new();
    init_thr = THR_RESET;
    tmo_ticks = TMO_RESET;
    acked = '0;
    win_end = 32'd1;
    win_len = 1;
    thr = init_thr;
    marker = '0;
    total = '0;
    busy = 1'b0;
    clear_timers();
    errors = 0;
    checked = 0;
    resent = 0;
    timeouts = 0;
    commands = 0;
  endfunction

  function void set_regs(logic [THR_W-1:0] t, logic [TMR_W-1:0] ticks);
    init_thr = t;
    tmo_ticks = ticks;
  endfunction

  function void clear_timers();
    int k;
    for (k = 0; k < NSLOT; k++) begin
      timer[k] = '0;
      armed[k] = 1'b0;
    end
  endfunction

  function void arm(logic [SEQ_W-1:0] s);
    timer[s[SLOT_W-1:0]] = (tmo_ticks == 0) ? 16'd1 : tmo_ticks;
    armed[s[SLOT_W-1:0]] = 1'b1;
  endfunction

  function void emit(logic [1:0] k, logic [SEQ_W-1:0] s, logic r);
    seg_item_t e;
    e.kind = k;
    e.seq = s;
    e.rtx = r;
    e.last = 1'b0;
    step_segs.push_back(e);
  endfunction

  function int unsigned cap_win(int unsigned v);
    return (v > WIN_MAX) ? WIN_MAX : v;
  endfunction

  function int unsigned span_len();
    logic [SEQ_W-1:0] c;
    c = win_end - acked;
    return (c > WIN_MAX) ? WIN_MAX : c;
  endfunction

  function void emit_window();
    int unsigned c;
    int unsigned k;
    longint unsigned s;
    c = span_len();
    for (k = 1; k <= c && step_segs.size() < WIN_MAX; k++) begin
      s = acked;
      s += k;
      if (s > SEQ_TOP) break;
      if (s <= total) begin
        emit(KIND_DATA, s[SEQ_W-1:0], 1'b0);
        arm(s[SEQ_W-1:0]);
      end else begin
        // past the last data segment: the end marker takes this sequence
        emit(KIND_END, s[SEQ_W-1:0], 1'b0);
        marker = s[SEQ_W-1:0];
        break;
      end
    end
  endfunction

  function void resend_outstanding();
    int unsigned c;
    int unsigned k;
    longint unsigned s;
    c = span_len();
    for (k = 1; k <= c && step_segs.size() < WIN_MAX; k++) begin
      s = acked;
      s += k;
      if (s > SEQ_TOP) break;
      armed[s[SLOT_W-1:0]] = 1'b0;
      timer[s[SLOT_W-1:0]] = '0;
      if (marker == 0 || s <= marker) begin
        emit((marker != 0 && s == marker) ? KIND_END : KIND_DATA, s[SEQ_W-1:0], 1'b1);
        arm(s[SEQ_W-1:0]);
      end
    end
  endfunction

  // returns 0 when the block just drops the command
  function bit note_command(logic [1:0] cmd, logic [SEQ_W-1:0] ack, logic [SEQ_W-1:0] cnt);
    bit took;
    bit fired;
    int k;
    took = 1'b1;
    step_segs.delete();
    if (cmd == CMD_START) begin
      total = (cnt > SEG_MAX) ? SEG_MAX : cnt;
      acked = '0;
      thr = init_thr;
      win_len = 1;
      win_end = 32'd1;
      marker = '0;
      clear_timers();
      busy = 1'b1;
      emit_window();
    end else if (cmd == CMD_ACK && busy) begin
      if (ack == 0) begin
        acked = '0;
        marker = '0;
        busy = 1'b0;
        clear_timers();
        emit(KIND_COMPLETE, '0, 1'b0);
      end else if (ack == acked + 32'd1) begin
        acked = ack;
        armed[acked[SLOT_W-1:0]] = 1'b0;
        timer[acked[SLOT_W-1:0]] = '0;
        if (acked == win_end) begin
          if (win_len < thr) win_len = cap_win(win_len * 2);
          else win_len = cap_win(win_len + 1);
          win_end = (SEQ_TOP - win_end < win_len) ? SEQ_TOP : win_end + win_len;
          emit_window();
        end
      end else begin
        took = 1'b0;
      end
    end else if (cmd == CMD_TICK && busy) begin
      fired = 1'b0;
      for (k = 0; k < NSLOT; k++) begin
        if (armed[k]) begin
          if (timer[k] > 0) timer[k]--;
          if (timer[k] == 0) begin
            armed[k] = 1'b0;
            fired = 1'b1;
          end
        end
      end
      // several expiries in one tick are a single timeout
      if (fired) begin
        timeouts++;
        thr = thr / 2;
        win_len = cap_win(thr + 3);
        resend_outstanding();
      end
    end else begin
      took = 1'b0;
    end
    if (step_segs.size() > 0) step_segs[step_segs.size()-1].last = 1'b1;
    foreach (step_segs[i]) segs_due.push_back(step_segs[i]);
    if (took) commands++;
    return took;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%t ERROR %s", $realtime, msg);
  endfunction

  function void check_segment(logic [1:0] k, logic [SEQ_W-1:0] s, logic r, logic l);
    seg_item_t e;
    checked++;
    if (r) resent++;
    if (segs_due.size() == 0) begin
      flag($sformatf("unexpected transfer: kind %0d seq %0d rtx %0b last %0b", k, s, r, l));
      return;
    end
    e = segs_due.pop_front();
    if (e.kind !== k || e.seq !== s || e.rtx !== r || e.last !== l)
      flag($sformatf("exp kind %0d seq %0d rtx %0b last %0b, got kind %0d seq %0d rtx %0b last %0b",
                     e.kind, e.seq, e.rtx, e.last, k, s, r, l));
  endfunction

  function int pending();
    return segs_due.size();
  endfunction
endclass

module go_back_n_window_sender_tb;
  localparam int RST_CYCLES   = 8;
  localparam int QUIET_CYCLES = 160;   // tick sweep plus a full resend
  localparam int STALL_LIMIT  = 5000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata = '0;   // ack_seq, segment_count
  logic [1:0]           in_tuser = '0;   // cmd
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;       // seq
  logic [2:0]           out_tuser;       // kind, is_retransmit
  logic                 out_tlast;

  segment_scoreboard sb = new();
  int src_idle_pct = 29;
  int sink_idle_pct = 48;
  int stall_cnt = 0;
  int phases = 0;

  go_back_n_window_sender uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // receiver side: random stalls, every transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_segment(out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] c, input logic [31:0] a, input logic [31:0] n,
                          output bit counted);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {n, a};
    do @(posedge clk); while (!in_tready);
    counted = sb.note_command(c, a, n);
  endtask

  task automatic send(input logic [1:0] c, input logic [31:0] a, input logic [31:0] n);
    bit counted;
    push_cmd(c, a, n, counted);
  endtask

  // hold off the sender until every predicted segment is out, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [TMR_W-1:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= REG_INIT_THR;
    cfg_data <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(thr, tmo);
  endtask

  // mostly in-order acks and ticks on a running transfer, some restarts and noise
  task automatic random_item(output bit counted);
    int unsigned r;
    logic [1:0]  c;
    logic [31:0] a;
    logic [31:0] n;
    r = $urandom_range(99);
    a = $urandom;
    n = $urandom;
    if (!sb.busy || r < 4) begin
      c = CMD_START;
      case ($urandom_range(19))
        0:       n = 32'hFFFF_FFFF;
        1:       ;   // full-width random count
        2, 3:    n = $urandom_range(300, 41);
        default: n = $urandom_range(40);
      endcase
    end else if (r < 66) begin
      c = CMD_ACK;
      a = sb.acked + 32'd1;
    end else if (r < 84) begin
      c = CMD_TICK;
    end else if (r < 88) begin
      c = CMD_ACK;
      a = '0;
    end else if (r < 95) begin
      c = CMD_ACK;   // random ack, nearly always out of order
    end else begin
      c = CMD_UNUSED;
    end
    push_cmd(c, a, n, counted);
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [TMR_W-1:0] tmo,
                           input int src_pct, input int sink_pct, input int n_items);
    int  taken;
    bit  counted;
    taken = 0;
    set_config(thr, tmo);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    while (taken < n_items) begin
      random_item(counted);
      taken++;
    end
    settle();
    phases++;
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: threshold 32, one tick timeout
    send(CMD_ACK, 32'd5, '0);                  // no transfer running
    send(CMD_TICK, '0, '0);
    send(CMD_UNUSED, '1, '1);
    send(CMD_START, '0, 32'd0);                // empty transfer: marker only
    send(CMD_ACK, 32'd1, '0);                  // ack of the marker
    send(CMD_ACK, 32'd0, '0);
    send(CMD_START, '0, 32'hFFFF_FFFF);        // count above the top is clipped
    send(CMD_ACK, 32'd1, '0);
    send(CMD_ACK, 32'd3, '0);                  // out of order
    send(CMD_ACK, 32'd2, '0);
    send(CMD_ACK, 32'd3, '0);
    send(CMD_TICK, '0, '0);                    // expiry resends the window
    send(CMD_ACK, 32'd4, '0);
    send(CMD_ACK, 32'd5, '0);
    send(CMD_START, 32'hFFFF_FFFF, 32'd3);     // restart while running
    send(CMD_ACK, 32'd1, '0);
    send(CMD_ACK, 32'd2, '0);
    send(CMD_ACK, 32'd3, '0);
    send(CMD_TICK, '0, '0);                    // the unacked end marker runs no timer
    send(CMD_ACK, 32'hFFFF_FFFF, '0);
    send(CMD_ACK, 32'd0, '0);
    send(CMD_ACK, 32'd0, '0);
    settle();
    phases++;

    run_phase(7'd64, 16'd2,     29, 48, 65);
    run_phase(7'd1,  16'd0,     29, 48, 65);   // zero timeout, threshold halves to zero
    run_phase(7'd1,  16'hFFFF,  48, 29, 65);
    run_phase(7'd23, 16'd3,     48, 29, 65);
    run_phase(7'd64, 16'd1,     0,  0,  65);
    run_phase(7'd5,  16'd1,     0,  0,  65);

    $display("covered %0d commands over %0d settings: %0d segments checked, %0d resent",
             sb.commands, phases, sb.checked, sb.resent);
    $display("%0d timeouts, %0d mismatches, %0d results never seen",
             sb.timeouts, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
